/* hdl/gcm_pkg.sv */
// Package for the gradient colour mapper: widths, register indexes,
// stop word field helpers and the divider interface structs.
// No dependencies; used by gcm_divider and gradient_color_mapper.
`timescale 1ns / 1ps
`default_nettype none

package gcm_pkg;

    localparam int MAX_STOPS     = 7;
    localparam int NUM_STOP_REGS = 7;
    localparam int SEG_COUNT     = MAX_STOPS - 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 3;
    localparam int STOP_SEL_W  = $clog2(NUM_STOP_REGS);

    localparam int POS_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int CHANNELS   = 4;
    localparam int ALPHA_FRAC = 16;
    localparam int ALPHA_W    = ALPHA_FRAC + 1;
    localparam int PROD_W     = CHAN_W + ALPHA_W;
    localparam int DIV_STAGES = ALPHA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_FIRST = CFG_INDEX_W'(1);

    typedef logic [CFG_DATA_W-1:0] stop_word_t;

    // Channel 3 is red, 2 green, 1 blue, 0 opacity, as packed in a stop word.
    typedef logic [CHANNELS-1:0][CHAN_W-1:0] colour_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] numerator;
        logic [POS_W-1:0] divisor;
        colour_t          lo_colour;
        colour_t          hi_colour;
    } div_in_t;

    typedef struct packed {
        logic               valid;
        logic [ALPHA_W-1:0] quotient;
        colour_t            lo_colour;
        colour_t            hi_colour;
    } div_out_t;

    function automatic logic signed [POS_W-1:0] stop_position(input stop_word_t word);
        stop_position = signed'(word[CFG_DATA_W-1 -: POS_W]);
    endfunction

    function automatic colour_t stop_colour(input stop_word_t word);
        stop_colour = colour_t'(word[CHANNELS*CHAN_W-1:0]);
    endfunction

endpackage

`default_nettype wire

/* hdl/gcm_divider.sv */
// Pipelined restoring divider producing the UQ1.16 blend fraction,
// one quotient bit per stage, with the stop colours carried alongside.
// Depends on gcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcm_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire gcm_pkg::div_in_t div_in,
    output gcm_pkg::div_out_t     div_out
);

    localparam int STAGES = gcm_pkg::DIV_STAGES;
    localparam int W      = gcm_pkg::POS_W;
    localparam int QW     = gcm_pkg::ALPHA_W;

    logic [STAGES-1:0]   valid_reg;
    logic [W-1:0]        rem_reg     [STAGES];
    logic [W-1:0]        rem_next    [STAGES];
    logic [W-1:0]        span_reg    [STAGES];
    logic [QW-1:0]       quot_reg    [STAGES];
    logic [QW-1:0]       quot_next   [STAGES];
    gcm_pkg::colour_t    lo_reg      [STAGES];
    gcm_pkg::colour_t    hi_reg      [STAGES];
    logic [W:0]          shifted     [STAGES];
    logic [W:0]          diff        [STAGES];
    logic [STAGES-1:0]   take;

    // The numerator never exceeds the divisor, so the top quotient bit is a
    // single compare and every later remainder stays below the divisor.
    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                shifted[k] = {1'b0, div_in.numerator};
                diff[k]    = shifted[k] - {1'b0, div_in.divisor};
                take[k]    = (shifted[k] >= {1'b0, div_in.divisor});
                quot_next[k] = QW'(take[k]);
            end
            else
            begin
                shifted[k] = {rem_reg[k-1], 1'b0};
                diff[k]    = shifted[k] - {1'b0, span_reg[k-1]};
                take[k]    = (shifted[k] >= {1'b0, span_reg[k-1]});
                quot_next[k] = {quot_reg[k-1][QW-2:0], take[k]};
            end
            rem_next[k] = take[k] ? diff[k][W-1:0] : shifted[k][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], div_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                quot_reg[k] <= quot_next[k];
                if (k == 0)
                begin
                    span_reg[k] <= div_in.divisor;
                    lo_reg[k]   <= div_in.lo_colour;
                    hi_reg[k]   <= div_in.hi_colour;
                end
                else
                begin
                    span_reg[k] <= span_reg[k-1];
                    lo_reg[k]   <= lo_reg[k-1];
                    hi_reg[k]   <= hi_reg[k-1];
                end
            end
        end
    end

    assign div_out.valid     = valid_reg[STAGES-1];
    assign div_out.quotient  = quot_reg[STAGES-1];
    assign div_out.lo_colour = lo_reg[STAGES-1];
    assign div_out.hi_colour = hi_reg[STAGES-1];

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-1] && quot_reg[STAGES-1][QW-1]
            |-> quot_reg[STAGES-1][QW-2:0] == '0)
        else $error("blend fraction above one");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-1] |-> rem_reg[STAGES-1] < span_reg[STAGES-1])
        else $error("divider remainder not below divisor");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("divider valid bits moved during a stall");

endmodule

`default_nettype wire

/* hdl/gradient_color_mapper.sv */
// A sample beat, once accepted, reaches the output as a valid result through 21
// register stages: search, operand select, 17 divider stages, products, output register.
// Throughput: one sample per cycle while the output is not stalled; the 17-stage divider is fully pipelined.
// A result beat held by the consumer stalls the whole pipeline in place.
// Reset clears all valid bits, sets stop_count to one and every stop to zero.
// Depends on gcm_pkg and gcm_divider.
`timescale 1ns / 1ps
`default_nettype none

module gradient_color_mapper (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire logic [gcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gcm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [gcm_pkg::POS_W-1:0]   sample_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [gcm_pkg::CHAN_W-1:0]              red,
    output logic [gcm_pkg::CHAN_W-1:0]              green,
    output logic [gcm_pkg::CHAN_W-1:0]              blue,
    output logic [gcm_pkg::CHAN_W-1:0]              opacity
);

    localparam int W    = gcm_pkg::POS_W;
    localparam int SEGS = gcm_pkg::SEG_COUNT;
    localparam int CH   = gcm_pkg::CHANNELS;
    localparam int PW   = gcm_pkg::PROD_W;

    // Configuration registers.
    logic [gcm_pkg::COUNT_W-1:0]    stop_count_reg;
    gcm_pkg::stop_word_t            stop_reg [gcm_pkg::NUM_STOP_REGS];
    logic [gcm_pkg::STOP_SEL_W-1:0] stop_sel;

    logic advance;

    // Stage 1: segment search.
    logic [gcm_pkg::COUNT_W-1:0]    count_eff;
    logic [SEGS-1:0]                seg_ok;
    logic [SEGS-1:0]                sel_next;
    logic                           found;
    logic                           s1_valid_reg;
    logic signed [W-1:0]            s1_sample_reg;
    logic [SEGS-1:0]                s1_sel_reg;

    // Stage 2: operand select and subtraction.
    gcm_pkg::stop_word_t            lo_or;
    gcm_pkg::stop_word_t            hi_or;
    gcm_pkg::stop_word_t            lo_word;
    gcm_pkg::stop_word_t            hi_word;
    logic                           hit;
    logic signed [W:0]              num_wide;
    logic signed [W:0]              span_wide;
    logic                           s2_valid_reg;
    logic [W-1:0]                   s2_num_reg;
    logic [W-1:0]                   s2_span_reg;
    gcm_pkg::colour_t               s2_lo_reg;
    gcm_pkg::colour_t               s2_hi_reg;

    gcm_pkg::div_in_t               div_in;
    gcm_pkg::div_out_t              div_out;

    // Blend stages.
    logic [gcm_pkg::ALPHA_W-1:0]    alpha_inv;
    logic                           b1_valid_reg;
    logic [PW-1:0]                  lo_prod_reg [CH];
    logic [PW-1:0]                  hi_prod_reg [CH];
    logic [PW:0]                    blend_sum   [CH];
    logic                           out_valid_reg;
    gcm_pkg::colour_t               out_colour_reg;

    // The whole pipeline moves whenever the output register is free or being taken.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // ---------------- configuration ----------------
    assign stop_sel = cfg_index - gcm_pkg::REG_STOP_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= gcm_pkg::COUNT_W'(1);
            for (int i = 0; i < gcm_pkg::NUM_STOP_REGS; i++)
            begin
                stop_reg[i] <= '0;
            end
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == gcm_pkg::REG_STOP_COUNT)
            begin
                stop_count_reg <= cfg_data[gcm_pkg::COUNT_W-1:0];
            end
            else
            begin
                for (int i = 0; i < gcm_pkg::NUM_STOP_REGS; i++)
                begin
                    if (stop_sel == gcm_pkg::STOP_SEL_W'(i))
                    begin
                        stop_reg[i] <= cfg_data;
                    end
                end
            end
        end
    end

    // ---------------- stage 1 ----------------
    always_comb
    begin
        if (stop_count_reg == '0)
        begin
            count_eff = gcm_pkg::COUNT_W'(1);
        end
        else if (stop_count_reg > gcm_pkg::COUNT_W'(gcm_pkg::MAX_STOPS))
        begin
            count_eff = gcm_pkg::COUNT_W'(gcm_pkg::MAX_STOPS);
        end
        else
        begin
            count_eff = stop_count_reg;
        end

        found = 1'b0;
        for (int i = 0; i < SEGS; i++)
        begin
            seg_ok[i] = (gcm_pkg::COUNT_W'(i + 1) < count_eff)
                && (sample_value > gcm_pkg::stop_position(stop_reg[i]))
                && (sample_value <= gcm_pkg::stop_position(stop_reg[i+1]));
            // The first matching segment wins.
            sel_next[i] = seg_ok[i] && !found;
            found       = found || seg_ok[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sample_reg <= sample_value;
            s1_sel_reg    <= sel_next;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        lo_or = '0;
        hi_or = '0;
        for (int i = 0; i < SEGS; i++)
        begin
            lo_or = lo_or | ({gcm_pkg::CFG_DATA_W{s1_sel_reg[i]}} & stop_reg[i]);
            hi_or = hi_or | ({gcm_pkg::CFG_DATA_W{s1_sel_reg[i]}} & stop_reg[i+1]);
        end
        hit     = |s1_sel_reg;
        lo_word = hit ? lo_or : stop_reg[0];
        hi_word = hit ? hi_or : stop_reg[0];
        num_wide  = {s1_sample_reg[W-1], s1_sample_reg}
                  - {lo_word[gcm_pkg::CFG_DATA_W-1], gcm_pkg::stop_position(lo_word)};
        span_wide = {hi_word[gcm_pkg::CFG_DATA_W-1], gcm_pkg::stop_position(hi_word)}
                  - {lo_word[gcm_pkg::CFG_DATA_W-1], gcm_pkg::stop_position(lo_word)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Outside every segment the fraction is forced to zero with 0 / 1.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_num_reg  <= hit ? num_wide[W-1:0] : '0;
            s2_span_reg <= hit ? span_wide[W-1:0] : W'(1);
            s2_lo_reg   <= gcm_pkg::stop_colour(lo_word);
            s2_hi_reg   <= gcm_pkg::stop_colour(hi_word);
        end
    end

    assign div_in.valid     = s2_valid_reg;
    assign div_in.numerator = s2_num_reg;
    assign div_in.divisor   = s2_span_reg;
    assign div_in.lo_colour = s2_lo_reg;
    assign div_in.hi_colour = s2_hi_reg;

    gcm_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .div_in  (div_in),
        .div_out (div_out)
    );

    // ---------------- blend ----------------
    assign alpha_inv = gcm_pkg::ALPHA_ONE - div_out.quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg  <= div_out.valid;
            out_valid_reg <= b1_valid_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            blend_sum[c] = {1'b0, lo_prod_reg[c]} + {1'b0, hi_prod_reg[c]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < CH; c++)
            begin
                lo_prod_reg[c] <= PW'(div_out.lo_colour[c]) * PW'(alpha_inv);
                hi_prod_reg[c] <= PW'(div_out.hi_colour[c]) * PW'(div_out.quotient);
                out_colour_reg[c] <= blend_sum[c][gcm_pkg::ALPHA_FRAC +: gcm_pkg::CHAN_W];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = out_colour_reg[3];
    assign green     = out_colour_reg[2];
    assign blue      = out_colour_reg[1];
    assign opacity   = out_colour_reg[0];

    a_one_segment: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(s1_sel_reg))
        else $error("more than one segment selected");

    a_operands: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_span_reg != '0) && (s2_num_reg <= s2_span_reg))
        else $error("blend operands out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s1_valid_reg) && $stable(s2_valid_reg)
            && $stable(b1_valid_reg) && out_valid_reg)
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
